>>> hw/rtl/systick_pkg.sv
// Shared constants for the extended tick timer core.
// Field widths, operation codes, register addresses and control bit positions.
// No dependencies.
package systick_pkg;

    localparam int CNT_W = 24;
    localparam int OVF_W = 32;
    localparam int RD_W  = 56;
    localparam int CTL_W = 3;
    localparam int FLAG_BIT = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] OP_TICK_PROC = 2'd0;
    localparam logic [1:0] OP_TICK_REF  = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_WRITE     = 2'd3;

    localparam logic [2:0] ADDR_CTRL    = 3'd0;
    localparam logic [2:0] ADDR_RELOAD  = 3'd1;
    localparam logic [2:0] ADDR_CURRENT = 3'd2;
    localparam logic [2:0] ADDR_OVF     = 3'd3;
    localparam logic [2:0] ADDR_ELAP24  = 3'd4;
    localparam logic [2:0] ADDR_ELAP64  = 3'd5;

    localparam int CTL_ENABLE  = 0;
    localparam int CTL_TICKINT = 1;
    localparam int CTL_CLKSRC  = 2;

    localparam logic CFG_ONE_SHOT = 1'b0;
    localparam logic CFG_OVF_EN   = 1'b1;

    typedef logic [RD_W-1:0] t_rdata;

endpackage

>>> hw/rtl/systick_timer_extended_core.sv
// Extended tick timer: down counter, reload, count flag, overflow counter.
// The request passes an input register, then a result register. Throughput:
// one request per cycle while the output is not stalled.
// Depends on systick_pkg.
// Reset (synchronous, active low) clears counter, reload, control, flag,
// overflow count, one-shot latch, both config registers and both valids.
module systick_timer_extended_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_opcode,
    input  logic [2:0]                    i_reg_addr,
    input  logic [23:0]                   i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [systick_pkg::RD_W-1:0]  o_read_data,
    output logic                          o_count_wrapped,
    output logic                          o_notify
);
    import systick_pkg::*;

    logic             r_one_shot, r_ovf_en;
    logic             r_in_valid, r_out_valid;
    logic [1:0]       r_op;
    logic [2:0]       r_addr;
    logic [23:0]      r_wdata;

    logic [CNT_W-1:0] r_cur, r_reload;
    logic [CTL_W-1:0] r_ctl;
    logic             r_flag, r_notified;
    logic [OVF_W-1:0] r_ovf;

    logic [CNT_W-1:0] n_cur, n_reload;
    logic [CTL_W-1:0] n_ctl;
    logic             n_flag, n_notified;
    logic [OVF_W-1:0] n_ovf;
    t_rdata           n_rd;
    logic             n_wrap, n_notify;

    t_rdata           r_rd;
    logic             r_wrap, r_notify;

    logic             advance;
    logic             tick_ok;
    logic [CNT_W-1:0] cur_dec;
    logic [OVF_W:0]   ovf_p1;
    t_rdata           elap64;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    assign cur_dec = r_cur - 1'b1;
    assign ovf_p1  = {1'b0, r_ovf} + 1'b1;
    assign elap64  = (RD_W'(ovf_p1) << CNT_W) - RD_W'(ovf_p1) - RD_W'(r_cur);

    assign tick_ok = r_ctl[CTL_ENABLE] &&
                     (((r_op == OP_TICK_PROC) && r_ctl[CTL_CLKSRC]) ||
                      ((r_op == OP_TICK_REF) && !r_ctl[CTL_CLKSRC]));

    always_comb begin
        n_cur      = r_cur;
        n_reload   = r_reload;
        n_ctl      = r_ctl;
        n_flag     = r_flag;
        n_notified = r_notified;
        n_ovf      = r_ovf;
        n_rd       = '0;
        n_wrap     = 1'b0;
        n_notify   = 1'b0;
        unique case (r_op)
            OP_TICK_PROC, OP_TICK_REF: begin
                if (tick_ok) begin
                    if (r_cur == '0) begin
                        n_cur = r_reload;
                    end else begin
                        n_cur = cur_dec;
                        if (cur_dec == '0) begin
                            n_wrap = 1'b1;
                            n_flag = 1'b1;
                            if (r_ctl[CTL_TICKINT]) begin
                                // serviced wrap: handler reads control
                                n_flag = 1'b0;
                                if (r_ovf_en) begin
                                    n_ovf = r_ovf + 1'b1;
                                end
                                if (!(r_one_shot && r_notified)) begin
                                    n_notify = 1'b1;
                                    if (r_one_shot) begin
                                        n_notified = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (r_addr)
                    ADDR_CTRL: begin
                        n_rd = RD_W'(r_ctl);
                        n_rd[FLAG_BIT] = r_flag;
                        n_flag = 1'b0;
                    end
                    ADDR_RELOAD:  n_rd = RD_W'(r_reload);
                    ADDR_CURRENT: n_rd = RD_W'(r_cur);
                    ADDR_OVF:     n_rd = RD_W'(r_ovf);
                    ADDR_ELAP24:  n_rd = RD_W'(CNT_MAX - r_cur);
                    ADDR_ELAP64:  n_rd = elap64;
                    default:      n_rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (r_addr)
                    ADDR_CTRL:   n_ctl = r_wdata[CTL_W-1:0];
                    ADDR_RELOAD: n_reload = r_wdata[CNT_W-1:0];
                    ADDR_CURRENT: begin
                        n_cur  = '0;
                        n_flag = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot  <= 1'b0;
            r_ovf_en    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_reload    <= '0;
            r_ctl       <= '0;
            r_flag      <= 1'b0;
            r_notified  <= 1'b0;
            r_ovf       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ONE_SHOT: r_one_shot <= i_cfg_data;
                    CFG_OVF_EN:   r_ovf_en   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_cur      <= n_cur;
                    r_reload   <= n_reload;
                    r_ctl      <= n_ctl;
                    r_flag     <= n_flag;
                    r_notified <= n_notified;
                    r_ovf      <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op    <= i_opcode;
            r_addr  <= i_reg_addr;
            r_wdata <= i_write_data;
        end
        if (advance && r_in_valid) begin
            r_rd     <= n_rd;
            r_wrap   <= n_wrap;
            r_notify <= n_notify;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_rd;
    assign o_count_wrapped = r_wrap;
    assign o_notify        = r_notify;

endmodule

>>> hw/rtl/systick_chk.sv
// Port-level checker for systick_timer_extended_core, with its bind.
// Depends on systick_pkg.
module systick_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_ready,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [systick_pkg::RD_W-1:0]  o_read_data,
    input  logic                          o_count_wrapped,
    input  logic                          o_notify
);
    import systick_pkg::*;

    a_notify_needs_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_notify |-> o_count_wrapped)
        else $error("notify without wrap");

    a_wrap_no_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_count_wrapped |-> o_read_data == '0)
        else $error("read data on tick result");

    a_ready_when_drained: assert property (@(posedge i_clk)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while output drains");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

endmodule

bind systick_timer_extended_core systick_chk u_systick_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_read_data    (o_read_data),
    .o_count_wrapped(o_count_wrapped),
    .o_notify       (o_notify)
);
